### rtl/tlff_pkg.sv
// ----------------------------------------------------------------------------
// tlff_pkg
// Types and constants shared by the line format filter modules.
// ----------------------------------------------------------------------------
package tlff_pkg;

	localparam int BCD_DIGITS = 6;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int FIELD_MAX  = 7;
	localparam int FIFO_DEPTH = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [BCD_W-1:0] BCD_ONE = 24'h000001;
	localparam logic [BCD_W-1:0] BCD_MAX = 24'h999999;

	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_QMARK  = 8'h3f;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DEL    = 8'h7f;
	localparam logic [7:0] CH_CTL_HI = 8'h1f;
	localparam logic [7:0] CARET_OFS = 8'h40;

	typedef enum logic [1:0] {
		NUM_NONE     = 2'd0,
		NUM_ALL      = 2'd1,
		NUM_NONBLANK = 2'd2
	} num_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUMBER_MODE = 3'd0,
		CFG_SQUEEZE     = 3'd1,
		CFG_NONPRINT    = 3'd2,
		CFG_ENDS        = 3'd3,
		CFG_TABS        = 3'd4
	} cfg_idx_t;

	// one queued descriptor: optional number prefix plus one or two body chars
	typedef struct packed {
		logic             pfx;
		logic [BCD_W-1:0] bcd;
		logic [2:0]       digits;
		logic [2:0]       field;
		logic             two;
		logic [7:0]       c0;
		logic [7:0]       c1;
	} desc_t;

endpackage

### rtl/text_line_format_filter.sv
// ----------------------------------------------------------------------------
// text_line_format_filter
// An accepted input word passes through the descriptor queue and then the
// registered output stage. One input word per cycle while the queue is not
// full; a burst of words (prefix plus body, at most ten) occupies the back end.
// The two-entry descriptor queue lets the front keep accepting meanwhile.
// Reset clears registers to 0, line state to line start, counter to 1.
// ----------------------------------------------------------------------------
module text_line_format_filter import tlff_pkg::*; #(
	parameter int NUMBER_WIDTH = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  new_file,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  last_of_run
);

	logic  q_full, q_push, q_pop, head_valid;
	desc_t q_data, head;

	tlff_front #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.new_file  (new_file),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	tlff_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tlff_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

### rtl/tlff_front.sv
// ----------------------------------------------------------------------------
// tlff_front
// Holds the registers and line state, classifies each input word and
// queues a burst descriptor for the back end.
// ----------------------------------------------------------------------------
module tlff_front import tlff_pkg::*; #(
	parameter int NUMBER_WIDTH = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  new_file,
	input  logic                  q_full,
	output logic                  q_push,
	output desc_t                 q_data
);

	localparam logic [2:0] WIDTH_EFF =
		3'(NUMBER_WIDTH > FIELD_MAX ? FIELD_MAX : NUMBER_WIDTH);

	logic [1:0]       number_mode_q;
	logic             squeeze_q, nonprint_q, ends_q, tabs_q;
	logic             line_start_q, prev_blank_q;
	logic [BCD_W-1:0] bcd_q;

	logic             accept;
	logic             als, plb, blank, drop, numbered;
	logic [BCD_W-1:0] num, num_inc;
	logic             carry;
	logic [2:0]       digits;
	logic [2:0]       dig_p1;
	logic             is_ctl;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	always_comb begin
		als   = new_file ? 1'b1 : line_start_q;
		plb   = new_file ? 1'b0 : prev_blank_q;
		num   = new_file ? BCD_ONE : bcd_q;
		blank = (in_byte == CH_NL);
		drop  = als && squeeze_q && plb && blank;
		numbered = als && ((number_mode_q == NUM_ALL) ||
			((number_mode_q == NUM_NONBLANK) && !blank && (in_byte != CH_NUL)));

		carry   = 1'b1;
		num_inc = '0;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (carry && num[4*k +: 4] == 4'd9) begin
				num_inc[4*k +: 4] = 4'd0;
			end else begin
				num_inc[4*k +: 4] = num[4*k +: 4] + {3'b000, carry};
				carry = 1'b0;
			end
		end
		if (num == BCD_MAX) begin
			num_inc = BCD_MAX;
		end

		digits = 3'd1;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (num[4*k +: 4] != 4'd0) begin
				digits = 3'(k + 1);
			end
		end
		dig_p1 = digits + 3'd1;

		q_data.pfx    = numbered;
		q_data.bcd    = num;
		q_data.digits = digits;
		q_data.field  = (WIDTH_EFF > dig_p1) ? WIDTH_EFF : dig_p1;

		is_ctl = (in_byte <= CH_CTL_HI) && (in_byte != CH_NL) && (in_byte != CH_TAB);
		q_data.two = 1'b1;
		q_data.c0  = CH_CARET;
		q_data.c1  = in_byte;
		if (nonprint_q && in_byte == CH_DEL) begin
			q_data.c1 = CH_QMARK;
		end else if (nonprint_q && is_ctl) begin
			q_data.c1 = in_byte + CARET_OFS;
		end else if (ends_q && blank) begin
			q_data.c0 = CH_DOLLAR;
			q_data.c1 = CH_NL;
		end else if (tabs_q && in_byte == CH_TAB) begin
			q_data.c1 = CH_I;
		end else begin
			q_data.two = 1'b0;
			q_data.c0  = in_byte;
		end

		q_push = accept && !drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q <= NUM_NONE;
			squeeze_q     <= 1'b0;
			nonprint_q    <= 1'b0;
			ends_q        <= 1'b0;
			tabs_q        <= 1'b0;
			line_start_q  <= 1'b1;
			prev_blank_q  <= 1'b0;
			bcd_q         <= BCD_ONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_NUMBER_MODE: number_mode_q <= cfg_data[1:0];
					CFG_SQUEEZE:     squeeze_q     <= cfg_data[0];
					CFG_NONPRINT:    nonprint_q    <= cfg_data[0];
					CFG_ENDS:        ends_q        <= cfg_data[0];
					CFG_TABS:        tabs_q        <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				if (drop) begin
					line_start_q <= 1'b1;
					prev_blank_q <= plb;
					bcd_q        <= num;
				end else begin
					line_start_q <= blank;
					prev_blank_q <= als ? blank : plb;
					bcd_q        <= numbered ? num_inc : num;
				end
			end
		end
	end

endmodule

### rtl/tlff_fifo.sv
// ----------------------------------------------------------------------------
// tlff_fifo
// Short descriptor queue between front and back end.
// ----------------------------------------------------------------------------
module tlff_fifo import tlff_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	desc_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/tlff_back.sv
// ----------------------------------------------------------------------------
// tlff_back
// Expands the head descriptor into output words, one per cycle unless
// out_ready stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module tlff_back import tlff_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  desc_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic [3:0] pos_q;
	logic       out_valid_q, last_q;
	logic [7:0] out_byte_q;

	logic       advance, last_now;
	logic [3:0] prefix_len, total_m1, field4, pad_end;
	logic [2:0] k;
	logic [3:0] nib;
	logic [7:0] ch;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	always_comb begin
		field4     = {1'b0, head.field};
		pad_end    = field4 - {1'b0, head.digits};
		prefix_len = head.pfx ? field4 + 4'd1 : 4'd0;
		total_m1   = prefix_len + {3'b000, head.two};
		k          = head.field - 3'd1 - pos_q[2:0];
		case (k)
			3'd0:    nib = head.bcd[3:0];
			3'd1:    nib = head.bcd[7:4];
			3'd2:    nib = head.bcd[11:8];
			3'd3:    nib = head.bcd[15:12];
			3'd4:    nib = head.bcd[19:16];
			3'd5:    nib = head.bcd[23:20];
			default: nib = 4'd0;
		endcase
		if (head.pfx && pos_q < pad_end) begin
			ch = CH_SPACE;
		end else if (head.pfx && pos_q < field4) begin
			ch = CH_ZERO + {4'd0, nib};
		end else if (head.pfx && pos_q == field4) begin
			ch = CH_TAB;
		end else if (pos_q == prefix_len) begin
			ch = head.c0;
		end else begin
			ch = head.c1;
		end
		advance  = head_valid && (!out_valid_q || out_ready);
		last_now = (pos_q == total_m1);
		pop      = advance && last_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q       <= last_now ? 4'd0 : pos_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= ch;
			last_q     <= last_now;
		end
	end

endmodule
